>>> rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types and constants for the insertion sorter: word formats on the
// two channels, the data and control carried along the chain of cells.
// ----------------------------------------------------------------------------
package isort_pkg;

  // Number of cells in the chain, one stored value each
  localparam int CAPACITY = 32;

  // Input word
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_set;
    logic               overflow;
  } out_word_t;

  // Contents of one cell, as seen by its neighbours
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
  } cell_data_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic insert;  // place the broadcast value into the chain
    logic drain;   // move every value one cell towards the output
  } cell_ctrl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_FILL = 2'b01,
    ST_EMIT = 2'b10
  } isort_state_t;

endpackage

>>> rtl/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell
// One cell of the sorting chain. Holds a single value and its valid bit.
// On insert it either keeps its value, takes the value of its left
// neighbour (shift right) or takes the new value; on drain it takes the
// value of its right neighbour.
// ----------------------------------------------------------------------------
module isort_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  isort_pkg::cell_ctrl_t     ctrl,
  input  logic signed [31:0]        new_value,
  input  isort_pkg::cell_data_t     left_data,
  input  logic                      left_gt,
  input  isort_pkg::cell_data_t     right_data,
  output isort_pkg::cell_data_t     data,
  output logic                      gt
);
  import isort_pkg::*;

  logic               valid;
  logic signed [31:0] value;
  logic               take;

  // Strictly greater, so equal values keep their arrival order
  assign gt   = valid && (value > new_value);
  // Cell moves on insert when its value is displaced, or it is the first empty one
  assign take = gt || (!valid && left_data.valid);

  assign data.valid = valid;
  assign data.value = value;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.drain) begin
      valid <= right_data.valid;
    end else if (ctrl.insert && take) begin
      valid <= 1'b1;
    end
  end

  // Value register
  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      value <= right_data.value;
    end else if (ctrl.insert && take) begin
      value <= left_gt ? left_data.value : new_value;
    end
  end

endmodule

>>> rtl/insertion_sorter_top.sv
// ----------------------------------------------------------------------------
// insertion_sorter_top
// Streaming insertion sorter built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel (item_valid / item_stall / item): one signed value per word,
//    item.last closes the set. Each value is inserted as it is taken: every
//    cell compares with the new value at once and the chain shifts in the
//    same cycle, so the next value can follow straight away.
//  - result channel (result_valid / result_stall / result): after the last
//    word, the set comes out in ascending order from the head cell, the
//    largest value flagged with end_of_set. The first result is valid the
//    cycle after the last word is taken; one result per cycle unless stalled.
//  - While results are being emitted item_stall is high; the channel reopens
//    the cycle after the final result is taken. At most CAPACITY values of a
//    set are kept.
//  - Values beyond CAPACITY are dropped and overflow is set on every result
//    of that set.
//  - A stalled result holds: the chain only drains on a taken word.
//  - Synchronous reset empties the chain and clears the overflow flag.
// ----------------------------------------------------------------------------
module insertion_sorter_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  isort_pkg::in_word_t   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output isort_pkg::out_word_t  result
);
  import isort_pkg::*;

  isort_state_t state, state_next;
  logic         dropped, dropped_next;
  cell_ctrl_t   ctrl;
  cell_data_t   chain [CAPACITY];
  logic         gt    [CAPACITY];
  logic         item_acc;
  logic         result_acc;
  logic         full;
  logic         final_word;

  assign full       = chain[CAPACITY-1].valid;
  assign item_stall = (state != ST_FILL);
  assign item_acc   = item_valid && !item_stall;
  assign result_acc = result_valid && !result_stall;
  assign final_word = result_acc && !chain[1].valid;

  assign ctrl.insert = item_acc && !full;
  assign ctrl.drain  = result_acc;

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_data_t left_d, right_d;
    logic       left_g;

    if (i == 0) begin : g_head
      assign left_d = '{valid: 1'b1, value: 32'sd0};
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_d = chain[i-1];
      assign left_g = gt[i-1];
    end

    if (i == CAPACITY-1) begin : g_tail
      assign right_d = '{valid: 1'b0, value: 32'sd0};
    end else begin : g_inner
      assign right_d = chain[i+1];
    end

    isort_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_value  (item.value),
      .left_data  (left_d),
      .left_gt    (left_g),
      .right_data (right_d),
      .data       (chain[i]),
      .gt         (gt[i])
    );
  end

  // Sequencer and overflow flag
  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    case (state)
      ST_FILL: begin
        if (item_acc && full) begin
          dropped_next = 1'b1;
        end
        if (item_acc && item.last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (final_word) begin
          state_next   = ST_FILL;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next   = ST_FILL;
        dropped_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_FILL;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  // Result word straight from the head cell
  assign result_valid        = (state == ST_EMIT);
  assign result.sorted_value = chain[0].value;
  assign result.end_of_set   = !chain[1].valid;
  assign result.overflow     = dropped;

endmodule
